// ===== sv/ilwm_pkg.sv =====
// ----------------------------------------------------------------------------
// ilwm_pkg - shared types and constants for the ILIKE wildcard matcher
// Pattern geometry, configuration register indexes and the decoded
// configuration bundle passed from the register block to the match core.
// ----------------------------------------------------------------------------
package ilwm_pkg;

	// pattern storage is four 64-bit words of eight characters each
	localparam int PAT_CHARS  = 32;
	// characters actually used for matching and depth of the text window
	localparam int PAT_MAX    = 32;
	localparam int POS_W      = $clog2(PAT_MAX);
	// segment index, counts and lengths
	localparam int CNT_W      = 6;
	localparam int WORD_W     = 64;
	localparam int WORDS      = PAT_CHARS / 8;
	localparam int CHAR_W     = 8;
	localparam int CS_SAT     = 63;

	// ASCII case folding
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] ALPHA_COUNT  = 8'd26;
	localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_WORD_A   = 3'd0,
		REG_WORD_B   = 3'd1,
		REG_WORD_C   = 3'd2,
		REG_WORD_D   = 3'd3,
		REG_END_MASK = 3'd4,
		REG_LENGTH   = 3'd5,
		REG_LEAD     = 3'd6,
		REG_TRAIL    = 3'd7
	} cfg_reg_t;

	typedef logic [PAT_MAX-1:0][CHAR_W-1:0] window_t;

	// decoded pattern: characters, segment ends and per-position segment number
	typedef struct packed {
		logic [PAT_CHARS-1:0][CHAR_W-1:0] pat;
		logic [CNT_W-1:0]                 n_used;
		logic [PAT_MAX-1:0]               seg_end;
		logic [PAT_MAX-1:0][CNT_W-1:0]    seg_num;
		logic [CNT_W-1:0]                 seg_count;
		logic                             lead;
		logic                             trail;
	} cfg_t;

endpackage

// ===== sv/ilwm_cfg.sv =====
// ----------------------------------------------------------------------------
// ilwm_cfg - configuration registers and pattern decode
// Holds the written registers and, in step with them, the decoded segment
// map: which positions end a segment and which segment each position is in.
// ----------------------------------------------------------------------------
module ilwm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [2:0]                      cfg_index,
	input  logic [ilwm_pkg::WORD_W-1:0]     cfg_data,
	output ilwm_pkg::cfg_t                  cfg
);

	logic [ilwm_pkg::WORDS-1:0][ilwm_pkg::WORD_W-1:0] word_q, word_nx;
	logic [31:0]                     mask_q, mask_nx;
	logic [ilwm_pkg::CNT_W-1:0]      len_q, len_nx;
	logic                            lead_q, lead_nx;
	logic                            trail_q, trail_nx;

	logic [ilwm_pkg::CNT_W-1:0]                        n_nx, n_q;
	logic [ilwm_pkg::PAT_MAX-1:0]                      end_nx, end_q;
	logic [ilwm_pkg::PAT_MAX-1:0][ilwm_pkg::CNT_W-1:0] num_nx, num_q;
	logic [ilwm_pkg::CNT_W-1:0]                        count_nx, count_q;

	// register write decode
	always_comb begin
		word_nx  = word_q;
		mask_nx  = mask_q;
		len_nx   = len_q;
		lead_nx  = lead_q;
		trail_nx = trail_q;
		if (cfg_wr_en) begin
			unique case (ilwm_pkg::cfg_reg_t'(cfg_index))
				ilwm_pkg::REG_WORD_A:   word_nx[0] = cfg_data;
				ilwm_pkg::REG_WORD_B:   word_nx[1] = cfg_data;
				ilwm_pkg::REG_WORD_C:   word_nx[2] = cfg_data;
				ilwm_pkg::REG_WORD_D:   word_nx[3] = cfg_data;
				ilwm_pkg::REG_END_MASK: mask_nx    = cfg_data[31:0];
				ilwm_pkg::REG_LENGTH:   len_nx     = cfg_data[ilwm_pkg::CNT_W-1:0];
				ilwm_pkg::REG_LEAD:     lead_nx    = cfg_data[0];
				ilwm_pkg::REG_TRAIL:    trail_nx   = cfg_data[0];
			endcase
		end
	end

	// segment map from the next register values, so it never lags a write
	always_comb begin
		logic [ilwm_pkg::PAT_MAX-1:0] below;
		below = '0;
		n_nx = (len_nx > ilwm_pkg::CNT_W'(ilwm_pkg::PAT_MAX)) ?
			ilwm_pkg::CNT_W'(ilwm_pkg::PAT_MAX) : len_nx;
		// the last character in use always closes a segment
		for (int p = 0; p < ilwm_pkg::PAT_MAX; p++) begin
			end_nx[p] = (ilwm_pkg::CNT_W'(p) < n_nx) &&
				(mask_nx[p] || (ilwm_pkg::CNT_W'(p + 1) == n_nx));
		end
		// segment number of a position = segment ends strictly below it
		for (int p = 0; p < ilwm_pkg::PAT_MAX; p++) begin
			for (int q = 0; q < ilwm_pkg::PAT_MAX; q++) begin
				below[q] = (q < p);
			end
			num_nx[p] = ilwm_pkg::CNT_W'($countones(end_nx & below));
		end
		count_nx = ilwm_pkg::CNT_W'($countones(end_nx));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			mask_q  <= '0;
			len_q   <= '0;
			lead_q  <= 1'b0;
			trail_q <= 1'b0;
			n_q     <= '0;
			end_q   <= '0;
			num_q   <= '0;
			count_q <= '0;
		end else begin
			word_q  <= word_nx;
			mask_q  <= mask_nx;
			len_q   <= len_nx;
			lead_q  <= lead_nx;
			trail_q <= trail_nx;
			n_q     <= n_nx;
			end_q   <= end_nx;
			num_q   <= num_nx;
			count_q <= count_nx;
		end
	end

	// byte 0 of word A is pattern character 0
	always_comb begin
		for (int w = 0; w < ilwm_pkg::WORDS; w++) begin
			for (int b = 0; b < 8; b++) begin
				cfg.pat[w*8 + b] = word_q[w][b*8 +: 8];
			end
		end
		cfg.n_used    = n_q;
		cfg.seg_end   = end_q;
		cfg.seg_num   = num_q;
		cfg.seg_count = count_q;
		cfg.lead      = lead_q;
		cfg.trail     = trail_q;
	end

endmodule

// ===== sv/ilwm_core.sv =====
// ----------------------------------------------------------------------------
// ilwm_core - per-character match step and text state
// Folds one character into the window, tests the current segment against
// the window and, at a text end, produces the verdict and clears the state.
// ----------------------------------------------------------------------------
module ilwm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ilwm_pkg::cfg_t                cfg,
	input  logic                          fire,
	input  logic [ilwm_pkg::CHAR_W-1:0]   text_char,
	input  logic                          last_char,
	input  logic                          empty_text,
	output logic                          has_result,
	output logic                          result
);

	ilwm_pkg::window_t            win_q, win_eff;
	logic [ilwm_pkg::CNT_W-1:0]   idx_q, cs_q, cs_eff, seg_len;
	logic                         failed_q, done_q, fail_n, done_n, adv;
	logic [ilwm_pkg::CHAR_W-1:0]  lc;
	logic [ilwm_pkg::PAT_MAX-1:0] seg_bits;
	logic [ilwm_pkg::POS_W-1:0]   end_pos;
	logic                         found, is_last, anch, cond_ok, eq, empty_pat;

	// lowercase and window shift; an empty-text item adds nothing
	always_comb begin
		lc = text_char;
		if ((text_char - ilwm_pkg::CHAR_UPPER_A) < ilwm_pkg::ALPHA_COUNT)
			lc = text_char | ilwm_pkg::CASE_BIT;
		if (empty_text) begin
			win_eff = win_q;
			cs_eff  = cs_q;
		end else begin
			win_eff = {win_q[ilwm_pkg::PAT_MAX-2:0], lc};
			cs_eff  = (cs_q == ilwm_pkg::CNT_W'(ilwm_pkg::CS_SAT)) ? cs_q : cs_q + 1'b1;
		end
	end

	// current segment: positions, end and length
	always_comb begin
		end_pos = '0;
		for (int p = 0; p < ilwm_pkg::PAT_MAX; p++) begin
			seg_bits[p] = (ilwm_pkg::CNT_W'(p) < cfg.n_used) && (cfg.seg_num[p] == idx_q);
			if (seg_bits[p] && cfg.seg_end[p])
				end_pos = end_pos | ilwm_pkg::POS_W'(p);
		end
		seg_len   = ilwm_pkg::CNT_W'($countones(seg_bits));
		found     = idx_q < cfg.seg_count;
		is_last   = idx_q == (cfg.seg_count - 1'b1);
		empty_pat = cfg.n_used == '0;
		anch      = (idx_q == '0) && !cfg.lead;
		cond_ok   = anch ? (cs_eff == seg_len) : (cs_eff >= seg_len);
	end

	// window compare: newest character lines up with the segment end
	always_comb begin
		logic [ilwm_pkg::POS_W-1:0] back;
		eq = 1'b1;
		for (int p = 0; p < ilwm_pkg::PAT_MAX; p++) begin
			back = end_pos - ilwm_pkg::POS_W'(p);
			if (seg_bits[p] && (win_eff[back] != cfg.pat[p]))
				eq = 1'b0;
		end
	end

	// segment advance for a character
	always_comb begin
		adv    = 1'b0;
		fail_n = failed_q;
		done_n = done_q;
		if (!empty_text && !failed_q && !done_q && !empty_pat) begin
			priority if (!found) begin
				done_n = 1'b1;
			end else if (is_last && !cfg.trail) begin
				// judged at the text end
				adv = 1'b0;
			end else if (anch) begin
				if (cs_eff == seg_len) begin
					if (eq)
						adv = 1'b1;
					else
						fail_n = 1'b1;
				end
			end else if (cs_eff >= seg_len && eq) begin
				adv = 1'b1;
			end
		end
		if (adv && is_last)
			done_n = 1'b1;
	end

	// verdict at the text end
	always_comb begin
		has_result = empty_text || last_char;
		priority if (empty_pat)
			result = 1'b1;
		else if (fail_n)
			result = 1'b0;
		else if (done_n)
			result = 1'b1;
		else if (adv)
			result = 1'b0;      // next segment just opened, nothing of it seen yet
		else if (!found)
			result = 1'b1;
		else if (!is_last || cfg.trail)
			result = 1'b0;
		else
			result = cond_ok && eq;
	end

	// text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			idx_q    <= '0;
			cs_q     <= '0;
			failed_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (fire) begin
			if (has_result) begin
				win_q    <= '0;
				idx_q    <= '0;
				cs_q     <= '0;
				failed_q <= 1'b0;
				done_q   <= 1'b0;
			end else begin
				win_q    <= win_eff;
				idx_q    <= adv ? idx_q + 1'b1 : idx_q;
				cs_q     <= adv ? '0 : cs_eff;
				failed_q <= fail_n;
				done_q   <= done_n;
			end
		end
	end

	// a failed anchor and all segments found exclude each other
	a_fail_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(failed_q && done_q))
		else $error("failed and done both set");

	// every text end leaves a clean state
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_result |=> idx_q == '0 && cs_q == '0 && !failed_q && !done_q)
		else $error("state not cleared after text end");

	// an advance restarts the character count
	a_adv_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !has_result && adv |=> cs_q == '0 && idx_q == $past(idx_q) + 1'b1)
		else $error("segment advance not taken");

endmodule

// ===== sv/ilwm_sv_dummy_never.sv =====
// ----------------------------------------------------------------------------
// ilwm_ostage - result register between the match core and the receiver
// Holds one verdict while the receiver stalls; frees as the transfer completes.
// ----------------------------------------------------------------------------
module ilwm_ostage (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic load_value,
	input  logic out_stall,
	output logic full,
	output logic out_valid,
	output logic matched
);

	logic valid_s2;
	logic matched_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			matched_s2 <= load_value;
	end

	// full means a new verdict can only enter once this one is taken
	assign full      = valid_s2 && out_stall;
	assign out_valid = valid_s2;
	assign matched   = matched_s2;

endmodule

// ===== sv/ilike_wildcard_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// ilike_wildcard_matcher_unit - case-insensitive ILIKE matcher, top level
// Text characters in, one match verdict out per text string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one text byte per transfer with
//   last_char marking the end of a string; empty_text stands for a whole
//   zero-length string (or closes a pending one without adding a byte).
//   Output channel (out_valid / out_stall): one transfer carrying matched
//   for every text end; bytes that do not end a string give nothing.
//   Configuration: cfg_wr_en / cfg_index / cfg_data write one register per
//   cycle; the user must write only while no string is in flight (the block does not enforce this).
//   Output path: a string end passes the input register, then the result
//   register, which drives out_valid.
//   Throughput: one character per cycle while in_stall is low. The segment
//   state update is a loop from the text state registers through the window
//   compare of the current segment.
//   Reset clears the configuration (empty pattern, matches everything),
//   the character window and all per-string state.
//   While the receiver stalls with a verdict waiting, bytes that end no
//   string keep flowing; the next string end is held in the input register
//   and in_stall is raised until the waiting verdict is taken.
// ----------------------------------------------------------------------------
module ilike_wildcard_matcher_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [2:0]                    cfg_index,
	input  logic [ilwm_pkg::WORD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ilwm_pkg::CHAR_W-1:0]   text_char,
	input  logic                          last_char,
	input  logic                          empty_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          matched
);

	ilwm_pkg::cfg_t               cfg;
	logic                         valid_s1;
	logic [ilwm_pkg::CHAR_W-1:0]  text_char_s1;
	logic                         last_char_s1;
	logic                         empty_text_s1;
	logic                         has_result, result, out_full, go;

	ilwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			text_char_s1  <= text_char;
			last_char_s1  <= last_char;
			empty_text_s1 <= empty_text;
		end
	end

	// a string end waits only when the result register cannot take it
	assign go       = valid_s1 && !(has_result && out_full);
	assign in_stall = valid_s1 && !go;

	ilwm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (go),
		.text_char  (text_char_s1),
		.last_char  (last_char_s1),
		.empty_text (empty_text_s1),
		.has_result (has_result),
		.result     (result)
	);

	ilwm_ostage u_ostage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (go && has_result),
		.load_value (result),
		.out_stall  (out_stall),
		.full       (out_full),
		.out_valid  (out_valid),
		.matched    (matched)
	);

	// stall is only raised against a held item
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && has_result)
		else $error("input stalled with nothing held");

	// a new verdict comes from a string end in the input register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && has_result))
		else $error("verdict without a string end");

	// a verdict waiting on the receiver blocks every string end behind it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && valid_s1 && has_result |-> in_stall)
		else $error("waiting verdict would be overwritten");

endmodule

// ===== verif/ilike_wildcard_matcher_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilike_wildcard_matcher_unit_test - self-checking bench for the ILIKE matcher
// Loads literal/percent patterns through the register port, streams text one
// byte per transfer with random gaps and output stalls, and compares every
// verdict with a cycle-free model of the greedy segment search.
// ----------------------------------------------------------------------------

// Verdict predictor: mirrors the pattern registers and the per-string state
class ilike_match_predictor;
	logic [ilwm_pkg::WORD_W-1:0]  words [ilwm_pkg::WORDS];
	logic [ilwm_pkg::PAT_MAX-1:0] end_mask;
	logic [ilwm_pkg::CNT_W-1:0]   pat_len;
	bit                           lead;
	bit                           trail;
	logic [ilwm_pkg::CHAR_W-1:0]  win [ilwm_pkg::PAT_MAX];
	int                           seg_idx;
	int                           since_seg;
	bit                           failed;
	bit                           done;
	bit                           pending_verdicts [$];
	int                           fault_count;

	function new();
		foreach (words[i]) words[i] = '0;
		end_mask = '0;
		pat_len = '0;
		lead = 0;
		trail = 0;
		fault_count = 0;
		clear_text();
	endfunction

	function void clear_text();
		foreach (win[i]) win[i] = '0;
		seg_idx = 0;
		since_seg = 0;
		failed = 0;
		done = 0;
	endfunction

	// register write; per-string state is left alone
	function void write_reg(ilwm_pkg::cfg_reg_t idx, logic [ilwm_pkg::WORD_W-1:0] v);
		case (idx)
			ilwm_pkg::REG_WORD_A:   words[0] = v;
			ilwm_pkg::REG_WORD_B:   words[1] = v;
			ilwm_pkg::REG_WORD_C:   words[2] = v;
			ilwm_pkg::REG_WORD_D:   words[3] = v;
			ilwm_pkg::REG_END_MASK: end_mask = v[ilwm_pkg::PAT_MAX-1:0];
			ilwm_pkg::REG_LENGTH:   pat_len = v[ilwm_pkg::CNT_W-1:0];
			ilwm_pkg::REG_LEAD:     lead = v[0];
			ilwm_pkg::REG_TRAIL:    trail = v[0];
			default:                ;
		endcase
	endfunction

	function int used_len();
		return (pat_len > ilwm_pkg::PAT_MAX) ? ilwm_pkg::PAT_MAX : int'(pat_len);
	endfunction

	function logic [ilwm_pkg::CHAR_W-1:0] pat_char(int i);
		return words[(i >> 3) & 3][(i & 7) * 8 +: 8];
	endfunction

	// bounds of segment idx; the final character in use always closes one
	function bit locate(int idx, output int start, output int len, output bit last_seg);
		int n;
		int s;
		int count;
		bit hit;
		n = used_len();
		s = 0;
		count = 0;
		hit = 0;
		start = 0;
		len = 0;
		last_seg = 0;
		for (int i = 0; i < n; i++) begin
			if (end_mask[i] || i + 1 == n) begin
				if (count == idx) begin
					start = s;
					len = i + 1 - s;
					hit = 1;
				end else if (hit) begin
					last_seg = 0;
					return 1;
				end
				count++;
				s = i + 1;
			end
		end
		if (hit)
			last_seg = 1;
		return hit;
	endfunction

	// newest byte sits at entry 0, so the segment reads backwards
	function bit window_holds(int start, int len);
		int back;
		for (int k = 0; k < len; k++) begin
			back = len - 1 - k;
			if (back >= ilwm_pkg::PAT_MAX || start + k >= ilwm_pkg::PAT_MAX)
				return 0;
			if (win[back] != pat_char(start + k))
				return 0;
		end
		return 1;
	endfunction

	function void shift_in(logic [ilwm_pkg::CHAR_W-1:0] raw);
		logic [ilwm_pkg::CHAR_W-1:0] c;
		logic [ilwm_pkg::CHAR_W-1:0] off;
		int start;
		int len;
		bit last_seg;
		c = raw;
		off = raw - ilwm_pkg::CHAR_UPPER_A;
		if (off < ilwm_pkg::ALPHA_COUNT)
			c = raw | ilwm_pkg::CASE_BIT;
		for (int i = ilwm_pkg::PAT_MAX - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = c;
		if (since_seg < ilwm_pkg::CS_SAT)
			since_seg++;
		if (failed || done || used_len() == 0)
			return;
		if (!locate(seg_idx, start, len, last_seg)) begin
			done = 1;
			return;
		end
		// an anchored final segment is only judged at the string end
		if (last_seg && !trail)
			return;
		if (seg_idx == 0 && !lead) begin
			if (since_seg != len)
				return;
			if (!window_holds(start, len)) begin
				failed = 1;
				return;
			end
		end else if (since_seg < len || !window_holds(start, len)) begin
			return;
		end
		seg_idx = (seg_idx + 1) & 63;
		since_seg = 0;
		if (last_seg)
			done = 1;
	endfunction

	function bit verdict();
		int start;
		int len;
		bit last_seg;
		if (used_len() == 0)
			return 1;
		if (failed)
			return 0;
		if (done)
			return 1;
		if (!locate(seg_idx, start, len, last_seg))
			return 1;
		if (!last_seg || trail)
			return 0;
		if (seg_idx == 0 && !lead) begin
			if (since_seg != len)
				return 0;
		end else if (since_seg < len) begin
			return 0;
		end
		return window_holds(start, len);
	endfunction

	// accepted input transfer
	function void record_transfer(logic [ilwm_pkg::CHAR_W-1:0] ch, bit last, bit empty);
		if (!empty)
			shift_in(ch);
		if (!empty && !last)
			return;
		pending_verdicts = {pending_verdicts, verdict()};
		clear_text();
	endfunction

	function void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	// accepted output transfer
	function void check_verdict(logic got);
		bit want;
		if (pending_verdicts.size() == 0) begin
			note_fault($sformatf("%0t: verdict %b with none outstanding", $realtime, got));
			return;
		end
		want = pending_verdicts.pop_front();
		if (got !== want)
			note_fault($sformatf("%0t: matched expected %b got %b", $realtime, want, got));
	endfunction
endclass

module ilike_wildcard_matcher_unit_test;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [2:0]                    cfg_index;
	logic [ilwm_pkg::WORD_W-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [ilwm_pkg::CHAR_W-1:0]   text_char;
	logic                          last_char;
	logic                          empty_text;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          matched;

	ilike_match_predictor board = new();

	// pattern as the bench builds it before loading
	logic [ilwm_pkg::CHAR_W-1:0]  pat_chars [ilwm_pkg::PAT_CHARS];
	logic [ilwm_pkg::PAT_MAX-1:0] pat_ends;
	logic [ilwm_pkg::CNT_W-1:0]   pat_len;
	bit                           pat_lead;
	bit                           pat_trail;
	logic [ilwm_pkg::CHAR_W-1:0]  text_buf [$];
	string                        filler_set = "abcxAB.";
	bit                           calm = 0;
	int                           items_sent = 0;

	ilike_wildcard_matcher_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_char  (text_char),
		.last_char  (last_char),
		.empty_text (empty_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.matched    (matched)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, off during the calm stretch
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 11);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_verdict(matched);
	end

	initial begin
		#3_000_000;
		$display("ilike_wildcard_matcher_unit regression: fail");
		$finish;
	end

	task automatic write_reg(ilwm_pkg::cfg_reg_t idx, logic [ilwm_pkg::WORD_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		board.write_reg(idx, v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// all eight registers; upper data bits sometimes carry junk
	task automatic load_pattern();
		logic [ilwm_pkg::WORD_W-1:0] w;
		logic [ilwm_pkg::WORD_W-1:0] junk;
		for (int k = 0; k < ilwm_pkg::WORDS; k++) begin
			for (int b = 0; b < 8; b++)
				w[b*8 +: 8] = pat_chars[k*8 + b];
			write_reg(ilwm_pkg::cfg_reg_t'(k), w);
		end
		junk = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
		write_reg(ilwm_pkg::REG_END_MASK,
			{junk[ilwm_pkg::WORD_W-1:ilwm_pkg::PAT_MAX], pat_ends});
		write_reg(ilwm_pkg::REG_LENGTH, {junk[ilwm_pkg::WORD_W-1:ilwm_pkg::CNT_W], pat_len});
		write_reg(ilwm_pkg::REG_LEAD, {junk[ilwm_pkg::WORD_W-1:1], pat_lead});
		write_reg(ilwm_pkg::REG_TRAIL, {junk[ilwm_pkg::WORD_W-1:1], pat_trail});
	endtask

	task automatic set_pattern(string s, logic [ilwm_pkg::PAT_MAX-1:0] ends,
			logic [ilwm_pkg::CNT_W-1:0] len, bit ld, bit tr);
		for (int i = 0; i < ilwm_pkg::PAT_CHARS; i++)
			pat_chars[i] = (i < s.len()) ? s[i] : 8'h00;
		pat_ends = ends;
		pat_len = len;
		pat_lead = ld;
		pat_trail = tr;
		load_pattern();
	endtask

	// one input transfer, sometimes after an idle gap with in_valid low
	task automatic push_char(logic [ilwm_pkg::CHAR_W-1:0] ch, bit last, bit empty);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 11)
			gap = 1;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		text_char  <= ch;
		last_char  <= last;
		empty_text <= empty;
		do @(posedge clk); while (in_stall);
		board.record_transfer(ch, last, empty);
		items_sent++;
	endtask

	// a whole string; close_empty ends it with an empty-text item instead
	task automatic send_text(logic [ilwm_pkg::CHAR_W-1:0] txt [$], bit close_empty);
		if (txt.size() == 0) begin
			push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			return;
		end
		foreach (txt[i])
			push_char(txt[i], (i == txt.size() - 1) && !close_empty, 1'b0);
		if (close_empty)
			push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic send_str(string s, bit close_empty);
		logic [ilwm_pkg::CHAR_W-1:0] q [$];
		for (int i = 0; i < s.len(); i++)
			q = {q, s[i]};
		send_text(q, close_empty);
	endtask

	// let outstanding verdicts out, then cover the pipeline depth
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic gen_pattern(int phase_no);
		int mode;
		mode = (phase_no <= 2) ? 1 : $urandom_range(0, 9);
		pat_lead = 1'($urandom_range(0, 1));
		pat_trail = 1'($urandom_range(0, 1));
		pat_ends = $urandom & $urandom;
		for (int i = 0; i < ilwm_pkg::PAT_CHARS; i++)
			pat_chars[i] = (mode <= 0 || mode == 2) ? 8'($urandom_range(0, 255))
				: 8'("a" + $urandom_range(0, 2));
		case (mode)
			0: pat_len = '0;
			1: begin
				pat_len = ilwm_pkg::CNT_W'($urandom_range(ilwm_pkg::PAT_MAX, 63));
				if (phase_no == 1) begin
					pat_len = '1;
					pat_ends = '1;
				end
				if (phase_no == 2) begin
					// one anchored segment spanning the whole window
					pat_len = ilwm_pkg::CNT_W'(ilwm_pkg::PAT_MAX);
					pat_ends = '0;
					pat_lead = 0;
					pat_trail = 0;
				end
			end
			2: pat_len = ilwm_pkg::CNT_W'($urandom_range(1, 6));
			default: pat_len = ilwm_pkg::CNT_W'($urandom_range(1, 8));
		endcase
	endtask

	function automatic logic [ilwm_pkg::CHAR_W-1:0] filler();
		return filler_set[$urandom_range(0, filler_set.len() - 1)];
	endfunction

	function automatic logic [ilwm_pkg::CHAR_W-1:0] flip_case(logic [ilwm_pkg::CHAR_W-1:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
			return c & ~ilwm_pkg::CASE_BIT;
		return c;
	endfunction

	// string built from the loaded segments, sometimes damaged, or noise
	task automatic build_text();
		int u;
		int idx;
		text_buf = {};
		u = (pat_len > ilwm_pkg::PAT_MAX) ? ilwm_pkg::PAT_MAX : int'(pat_len);
		if (u > 0 && $urandom_range(0, 9) < 7) begin
			if (pat_lead)
				repeat ($urandom_range(0, 3)) text_buf = {text_buf, filler()};
			for (int i = 0; i < u; i++) begin
				text_buf = {text_buf, flip_case(pat_chars[i])};
				if (pat_ends[i] && i + 1 < u)
					repeat ($urandom_range(0, 3)) text_buf = {text_buf, filler()};
			end
			if (pat_trail)
				repeat ($urandom_range(0, 3)) text_buf = {text_buf, filler()};
			if ($urandom_range(0, 9) < 3) begin
				idx = $urandom_range(0, text_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: text_buf[idx] = filler();
					1: text_buf.delete(idx);
					default: text_buf = {text_buf, filler()};
				endcase
			end
		end else begin
			repeat ($urandom_range(0, 10))
				text_buf = {text_buf, (($urandom_range(0, 1) == 1) ? filler()
					: 8'($urandom_range(0, 255)))};
		end
	endtask

	initial begin
		int phase_no;
		int strings;
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		text_char  = '0;
		last_char  = 1'b0;
		empty_text = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pattern after reset matches anything, the empty string too
		send_str("Z", 0);
		push_char(8'h00, 1'b0, 1'b1);
		drain();

		// anchored "ab" with no end bit set; case folding; closed by empty item
		set_pattern("ab", '0, 2, 0, 0);
		send_str("aB", 0);
		send_str("ab", 1);
		send_str("xab", 0);
		drain();

		// length above the window size is clamped
		set_pattern("abc", '0, 45, 1, 1);
		send_str("ab", 0);
		drain();

		// uppercase byte in the pattern never matches
		set_pattern("A", '0, 1, 1, 1);
		send_str("a", 0);
		drain();

		// extreme byte values: "%<00>%<ff>"
		pat_chars[0] = 8'h00;
		pat_chars[1] = 8'hff;
		pat_ends = 32'h1;
		pat_len = 2;
		pat_lead = 1;
		pat_trail = 0;
		load_pattern();
		text_buf = '{8'h00, 8'hff};
		send_text(text_buf, 0);
		text_buf = '{8'hff};
		send_text(text_buf, 0);
		drain();

		// reconfiguration with a string half done: index runs past the new pattern
		set_pattern("abc", 32'h3, 3, 0, 1);
		push_char("a", 1'b0, 1'b0);
		push_char("b", 1'b0, 1'b0);
		drain();
		set_pattern("a", '0, 1, 0, 1);
		push_char("q", 1'b1, 1'b0);
		drain();

		// random phases, each with a fresh pattern
		phase_no = 0;
		while (items_sent < 1000) begin
			phase_no++;
			calm = (phase_no >= 8 && phase_no < 12);
			drain();
			gen_pattern(phase_no);
			load_pattern();
			strings = (pat_len >= ilwm_pkg::PAT_MAX) ? 3 : $urandom_range(4, 12);
			repeat (strings) begin
				build_text();
				send_text(text_buf, $urandom_range(0, 9) == 0);
			end
		end
		calm = 0;
		drain();
		repeat (8) @(posedge clk);

		if (board.fault_count == 0 && board.pending_verdicts.size() == 0)
			$display("ilike_wildcard_matcher_unit regression: pass");
		else
			$display("ilike_wildcard_matcher_unit regression: fail");
		$finish;
	end

endmodule
